[sv/sdt_pkg.sv]
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared widths, constants and opcodes for the single data transfer unit.
// ----------------------------------------------------------------------------
package sdt_pkg;

    localparam int DATA_W        = 32;
    localparam int NUM_REGS      = 16;
    localparam int REG_AW        = 4;
    localparam int MEM_WORDS_DEF = 16384;
    localparam int OFFSET_W      = 12;

    // request opcodes
    localparam logic [1:0] OP_EXEC     = 2'd0;
    localparam logic [1:0] OP_LOAD_REG = 2'd1;
    localparam logic [1:0] OP_LOAD_MEM = 2'd2;

    // instruction bit positions
    localparam int BIT_P   = 24;
    localparam int BIT_U   = 23;
    localparam int BIT_L   = 20;
    localparam int RN_LSB  = 16;
    localparam int RD_LSB  = 12;

endpackage

[sv/sdt_ram.sv]
// ----------------------------------------------------------------------------
// sdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/sdt_alu.sv]
// ----------------------------------------------------------------------------
// sdt_alu
// Shared 32-bit add/subtract unit with carry out (carry = no borrow on sub).
// ----------------------------------------------------------------------------
module sdt_alu
    import sdt_pkg::*;
(
    input  logic              sub,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [DATA_W-1:0] sum,
    output logic              carry
);

    logic [DATA_W-1:0] b_eff;
    logic [DATA_W:0]   total;

    assign b_eff = sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, sub};
    assign sum   = total[DATA_W-1:0];
    assign carry = total[DATA_W];

endmodule

[sv/single_data_transfer_unit.sv]
// ----------------------------------------------------------------------------
// single_data_transfer_unit
// Load/store word unit over a 16-entry register file and a word memory.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. op
//   selects a transfer instruction, a register preload or a memory preload.
//   Each request gives exactly one result, shown for one cycle with done
//   high; the receiver cannot stall, so it must capture the result then.
// Sequencing:
//   Preloads: done in the cycle after the request; busy stays low, so a new
//   request may follow at once.
//   Transfers: all pass S_RD_BASE and S_RD_SRC; a fault or a pre-indexed store
//   ends there, a pre-indexed load adds S_ACCESS, a post-indexed store adds
//   S_WRBACK and a post-indexed load both. The single register file port (base
//   read, source read, load/base writeback) and registered memory read set
//   this order; one shared adder forms the offset address and the range check.
// Reset:
//   rst_n clears the sequencer, the result strobe and the register file
//   valid bits, so every register reads as zero until written. Memory words
//   have no reset and must be written before they are loaded.
// ----------------------------------------------------------------------------
module single_data_transfer_unit
    import sdt_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        op,
    input  logic [31:0]       instruction,
    input  logic [13:0]       preload_index,
    input  logic [31:0]       preload_value,
    output logic              done,
    output logic [31:0]       effective_address,
    output logic [31:0]       transfer_data,
    output logic [31:0]       base_after,
    output logic [3:0]        dest_reg,
    output logic              was_load,
    output logic              fault
);

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam logic [DATA_W-1:0] MEM_LIMIT = DATA_W'(MEM_WORDS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_BASE,
        S_RD_SRC,
        S_ACCESS,
        S_WRBACK
    } state_t;

    state_t state_reg, state_next;

    // latched request fields
    logic [REG_AW-1:0]   rn_reg, rn_next;
    logic [REG_AW-1:0]   rd_reg, rd_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                pre_reg, pre_next;
    logic                up_reg, up_next;
    logic                load_reg, load_next;
    logic [DATA_W-1:0]   base_reg, base_next;
    logic [DATA_W-1:0]   moved_reg, moved_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic [DATA_W-1:0]   ea_reg, ea_next;
    logic [NUM_REGS-1:0] valid_reg, valid_next;

    // result registers
    logic                done_reg, done_next;
    logic [DATA_W-1:0]   ea_out_reg, ea_out_next;
    logic [DATA_W-1:0]   data_out_reg, data_out_next;
    logic [DATA_W-1:0]   base_out_reg, base_out_next;
    logic [REG_AW-1:0]   dest_out_reg, dest_out_next;
    logic                load_out_reg, load_out_next;
    logic                fault_out_reg, fault_out_next;

    // register file port
    logic                rf_we;
    logic [REG_AW-1:0]   rf_waddr, rf_raddr;
    logic [DATA_W-1:0]   rf_wdata, rf_rdata, rf_value;

    // memory port
    logic                mem_we;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [DATA_W-1:0]   mem_wdata, mem_rdata;

    // shared adder
    logic                alu_sub, alu_carry;
    logic [DATA_W-1:0]   alu_a, alu_b, alu_sum;

    logic                accept;
    logic [DATA_W-1:0]   ea_now;
    logic [DATA_W-1:0]   pidx_ext;
    logic [REG_AW-1:0]   rf_raddr_q;

    sdt_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_regfile (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    sdt_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sdt_alu u_alu (
        .sub   (alu_sub),
        .a     (alu_a),
        .b     (alu_b),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // unwritten registers read as zero
    assign rf_value = valid_reg[rf_raddr_q] ? rf_rdata : '0;

    assign rf_raddr_q = (state_reg == S_RD_BASE) ? rn_reg : rd_reg;

    assign ea_now   = pre_reg ? moved_reg : base_reg;
    assign pidx_ext = {{(DATA_W-14){1'b0}}, preload_index};

    assign rf_raddr  = (state_reg == S_IDLE) ? instruction[RN_LSB +: REG_AW] : rd_reg;
    assign mem_raddr = ea_now[MEM_AW+1:2];

    // shared adder: offset add/sub while the base is read, range check after
    always_comb
    begin
        if (state_reg == S_RD_BASE)
        begin
            alu_a   = rf_value;
            alu_b   = {{(DATA_W-OFFSET_W){1'b0}}, offset_reg};
            alu_sub = !up_reg;
        end
        else
        begin
            alu_a   = {2'b00, ea_now[DATA_W-1:2]};
            alu_b   = MEM_LIMIT;
            alu_sub = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        rn_next        = rn_reg;
        rd_next        = rd_reg;
        offset_next    = offset_reg;
        pre_next       = pre_reg;
        up_next        = up_reg;
        load_next      = load_reg;
        base_next      = base_reg;
        moved_next     = moved_reg;
        data_next      = data_reg;
        ea_next        = ea_reg;
        valid_next     = valid_reg;
        done_next      = 1'b0;
        ea_out_next    = ea_out_reg;
        data_out_next  = data_out_reg;
        base_out_next  = base_out_reg;
        dest_out_next  = dest_out_reg;
        load_out_next  = load_out_reg;
        fault_out_next = fault_out_reg;
        rf_we          = 1'b0;
        rf_waddr       = rd_reg;
        rf_wdata       = data_reg;
        mem_we         = 1'b0;
        mem_waddr      = ea_now[MEM_AW+1:2];
        mem_wdata      = data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rn_next     = instruction[RN_LSB +: REG_AW];
                    rd_next     = instruction[RD_LSB +: REG_AW];
                    offset_next = instruction[OFFSET_W-1:0];
                    pre_next    = instruction[BIT_P];
                    up_next     = instruction[BIT_U];
                    load_next   = instruction[BIT_L];
                    if (op == OP_EXEC)
                    begin
                        state_next = S_RD_BASE;
                    end
                    else
                    begin
                        // preloads finish here; op 3 only returns zeros
                        done_next      = 1'b1;
                        ea_out_next    = '0;
                        data_out_next  = '0;
                        base_out_next  = '0;
                        dest_out_next  = '0;
                        load_out_next  = 1'b0;
                        fault_out_next = 1'b0;
                        if (op == OP_LOAD_REG)
                        begin
                            if (preload_index < 14'(NUM_REGS))
                            begin
                                rf_we    = 1'b1;
                                rf_waddr = preload_index[REG_AW-1:0];
                                rf_wdata = preload_value;
                                valid_next[preload_index[REG_AW-1:0]] = 1'b1;
                            end
                            else
                            begin
                                fault_out_next = 1'b1;
                            end
                        end
                        else if (op == OP_LOAD_MEM)
                        begin
                            if (pidx_ext < MEM_LIMIT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = pidx_ext[MEM_AW-1:0];
                                mem_wdata = preload_value;
                            end
                            else
                            begin
                                fault_out_next = 1'b1;
                            end
                        end
                    end
                end
            end

            S_RD_BASE:
            begin
                base_next  = rf_value;
                moved_next = alu_sum;
                state_next = S_RD_SRC;
            end

            S_RD_SRC:
            begin
                ea_next       = ea_now;
                ea_out_next   = ea_now;
                dest_out_next = rd_reg;
                load_out_next = load_reg;
                data_next     = rf_value;
                if (alu_carry)
                begin
                    // word index at or past the end of memory
                    done_next      = 1'b1;
                    data_out_next  = '0;
                    base_out_next  = base_reg;
                    fault_out_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (load_reg)
                begin
                    state_next = S_ACCESS;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rf_value;
                    if (pre_reg)
                    begin
                        done_next      = 1'b1;
                        data_out_next  = rf_value;
                        base_out_next  = base_reg;
                        fault_out_next = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_WRBACK;
                    end
                end
            end

            S_ACCESS:
            begin
                data_next        = mem_rdata;
                rf_we            = 1'b1;
                rf_waddr         = rd_reg;
                rf_wdata         = mem_rdata;
                valid_next[rd_reg] = 1'b1;
                if (pre_reg)
                begin
                    done_next      = 1'b1;
                    data_out_next  = mem_rdata;
                    base_out_next  = (rd_reg == rn_reg) ? mem_rdata : base_reg;
                    fault_out_next = 1'b0;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_WRBACK;
                end
            end

            S_WRBACK:
            begin
                // base writeback lands after a load into the same register
                rf_we              = 1'b1;
                rf_waddr           = rn_reg;
                rf_wdata           = moved_reg;
                valid_next[rn_reg] = 1'b1;
                done_next          = 1'b1;
                data_out_next      = data_reg;
                base_out_next      = moved_reg;
                fault_out_next     = 1'b0;
                state_next         = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rn_reg        <= '0;
            rd_reg        <= '0;
            offset_reg    <= '0;
            pre_reg       <= 1'b0;
            up_reg        <= 1'b0;
            load_reg      <= 1'b0;
            base_reg      <= '0;
            moved_reg     <= '0;
            data_reg      <= '0;
            ea_reg        <= '0;
            valid_reg     <= '0;
            done_reg      <= 1'b0;
            ea_out_reg    <= '0;
            data_out_reg  <= '0;
            base_out_reg  <= '0;
            dest_out_reg  <= '0;
            load_out_reg  <= 1'b0;
            fault_out_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rn_reg        <= rn_next;
            rd_reg        <= rd_next;
            offset_reg    <= offset_next;
            pre_reg       <= pre_next;
            up_reg        <= up_next;
            load_reg      <= load_next;
            base_reg      <= base_next;
            moved_reg     <= moved_next;
            data_reg      <= data_next;
            ea_reg        <= ea_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
            ea_out_reg    <= ea_out_next;
            data_out_reg  <= data_out_next;
            base_out_reg  <= base_out_next;
            dest_out_reg  <= dest_out_next;
            load_out_reg  <= load_out_next;
            fault_out_reg <= fault_out_next;
        end
    end

    assign done              = done_reg;
    assign effective_address = ea_out_reg;
    assign transfer_data     = data_out_reg;
    assign base_after        = base_out_reg;
    assign dest_reg          = dest_out_reg;
    assign was_load          = load_out_reg;
    assign fault             = fault_out_reg;

    // a result is only shown once the sequencer is back in idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // a faulting request never carries transfer data
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && fault) |-> (transfer_data == '0))
        else $error("faulting result carries data");

    // a new transfer never starts in the cycle a result is shown
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> !done)
        else $error("transfer started alongside a result");

    // the captured address of a transfer is what the result reports
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(busy)) |-> (effective_address == ea_reg))
        else $error("reported address differs from computed address");

endmodule

[bench/single_data_transfer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// single_data_transfer_unit_tb
// Drives a short table of directed requests (reset values, preload range
// faults, address extremes, writeback onto the loaded register, stores from
// the base register), then 1250 random requests sent in bursts. Every result
// is checked field by field against the row's stated result, or else against
// a local model of the register file and word memory, updated on each accept.
// ----------------------------------------------------------------------------
module single_data_transfer_unit_tb;
    import sdt_pkg::*;

    localparam int          MEM_WORDS       = MEM_WORDS_DEF;
    localparam int          MEM_AW          = $clog2(MEM_WORDS);
    localparam int          RANDOM_REQUESTS = 1250;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam logic [1:0]  OP_NONE         = 2'd3;

    typedef struct packed {
        logic [31:0] effective_address;
        logic [31:0] transfer_data;
        logic [31:0] base_after;
        logic [3:0]  dest_reg;
        logic        was_load;
        logic        fault;
    } xfer_result_t;

    typedef struct {
        logic [1:0]   req_op;
        logic [31:0]  ins;
        logic [13:0]  idx;
        logic [31:0]  val;
        bit           typed;
        xfer_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [31:0] instruction;
    logic [13:0] preload_index;
    logic [31:0] preload_value;
    logic        done;
    logic [31:0] effective_address;
    logic [31:0] transfer_data;
    logic [31:0] base_after;
    logic [3:0]  dest_reg;
    logic        was_load;
    logic        fault;

    // model state
    logic [31:0]  reg_image [NUM_REGS];
    logic [31:0]  mem_image [MEM_WORDS];
    bit           mem_written [MEM_WORDS];

    xfer_result_t due_outputs [$];
    stim_row_t    script [$];

    int mismatch_count;
    int results_checked;
    int request_count;
    int transfer_count;
    int load_count;
    int fault_count;
    int cycle_count;

    single_data_transfer_unit #(
        .MEM_WORDS(MEM_WORDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .instruction(instruction),
        .preload_index(preload_index),
        .preload_value(preload_value),
        .done(done),
        .effective_address(effective_address),
        .transfer_data(transfer_data),
        .base_after(base_after),
        .dest_reg(dest_reg),
        .was_load(was_load),
        .fault(fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] encode_transfer(bit pre, bit up, bit ld,
                                                    logic [3:0] rn, logic [3:0] rd,
                                                    logic [11:0] offset);
        logic [31:0] ins;
        ins = '0;
        ins[BIT_P] = pre;
        ins[BIT_U] = up;
        ins[BIT_L] = ld;
        ins[RN_LSB +: 4] = rn;
        ins[RD_LSB +: 4] = rd;
        ins[OFFSET_W-1:0] = offset;
        return ins;
    endfunction

    function automatic xfer_result_t outcome(logic [31:0] ea, logic [31:0] data,
                                             logic [31:0] base, logic [3:0] rd,
                                             logic ld, logic flt);
        xfer_result_t r;
        r.effective_address = ea;
        r.transfer_data = data;
        r.base_after = base;
        r.dest_reg = rd;
        r.was_load = ld;
        r.fault = flt;
        return r;
    endfunction

    function automatic stim_row_t stim_row(logic [1:0] req_op, logic [31:0] ins,
                                           logic [13:0] idx, logic [31:0] val,
                                           bit typed, xfer_result_t res);
        stim_row_t s;
        s.req_op = req_op;
        s.ins = ins;
        s.idx = idx;
        s.val = val;
        s.typed = typed;
        s.res = res;
        return s;
    endfunction

    // base register plus or minus the immediate, wrapping at 32 bits
    function automatic logic [31:0] indexed_base(logic [31:0] ins);
        logic [31:0] base;
        base = reg_image[ins[RN_LSB +: 4]];
        return ins[BIT_U] ? base + ins[OFFSET_W-1:0] : base - ins[OFFSET_W-1:0];
    endfunction

    // Works out the result of one request and commits it to the model state.
    function automatic xfer_result_t apply_request(logic [1:0] req_op, logic [31:0] ins,
                                                   logic [13:0] idx, logic [31:0] val);
        xfer_result_t r;
        logic [3:0]   rn;
        logic [3:0]   rd;
        logic [31:0]  moved;
        logic [31:0]  ea;
        r = '0;
        case (req_op)
            OP_EXEC:
            begin
                rn = ins[RN_LSB +: 4];
                rd = ins[RD_LSB +: 4];
                moved = indexed_base(ins);
                ea = ins[BIT_P] ? moved : reg_image[rn];
                r.effective_address = ea;
                r.dest_reg = rd;
                r.was_load = ins[BIT_L];
                if ((ea >> 2) >= MEM_WORDS)
                begin
                    r.fault = 1'b1;
                    r.base_after = reg_image[rn];
                end
                else
                begin
                    if (ins[BIT_L])
                    begin
                        r.transfer_data = mem_image[ea[MEM_AW+1:2]];
                        reg_image[rd] = mem_image[ea[MEM_AW+1:2]];
                    end
                    else
                    begin
                        r.transfer_data = reg_image[rd];
                        mem_image[ea[MEM_AW+1:2]] = reg_image[rd];
                        mem_written[ea[MEM_AW+1:2]] = 1'b1;
                    end
                    // writeback lands after the load, so it wins when Rd == Rn
                    if (!ins[BIT_P])
                        reg_image[rn] = moved;
                    r.base_after = reg_image[rn];
                end
            end
            OP_LOAD_REG:
            begin
                if (idx < NUM_REGS)
                    reg_image[idx[REG_AW-1:0]] = val;
                else
                    r.fault = 1'b1;
            end
            OP_LOAD_MEM:
            begin
                if (idx < MEM_WORDS)
                begin
                    mem_image[idx] = val;
                    mem_written[idx] = 1'b1;
                end
                else
                    r.fault = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Holds start high until the request is taken, then records its result.
    task automatic issue_request(input logic [1:0] req_op, input logic [31:0] ins,
                                 input logic [13:0] idx, input logic [31:0] val,
                                 input bit typed, input xfer_result_t typed_res);
        xfer_result_t predicted;
        start <= 1'b1;
        op <= req_op;
        instruction <= ins;
        preload_index <= idx;
        preload_value <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = apply_request(req_op, ins, idx, val);
        due_outputs.push_back(typed ? typed_res : predicted);
        request_count++;
        if (req_op == OP_EXEC)
        begin
            transfer_count++;
            if (predicted.was_load && !predicted.fault)
                load_count++;
        end
        if (predicted.fault)
            fault_count++;
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic draw_request(output logic [1:0] req_op, output logic [31:0] ins,
                                output logic [13:0] idx, output logic [31:0] val);
        int          pick;
        logic [31:0] ea;
        pick = $urandom_range(0, 99);
        ins = $urandom;
        idx = 14'($urandom);
        val = $urandom;
        if (pick < 12)
        begin
            req_op = OP_LOAD_REG;
            if ($urandom_range(0, 6) != 0)
                idx = 14'($urandom_range(0, NUM_REGS - 1));
            // mostly bases in a low window, some around the top of memory, the rest fully random
            case ($urandom_range(0, 7))
                0, 1: ;
                2: val = $urandom_range(4 * MEM_WORDS - 4200, 4 * MEM_WORDS + 200);
                default: val = $urandom_range(0, 2047);
            endcase
        end
        else if (pick < 24)
        begin
            req_op = OP_LOAD_MEM;
            if ($urandom_range(0, 2) != 0)
                idx = 14'($urandom_range(0, 1279));
        end
        else if (pick < 27)
            req_op = OP_NONE;
        else
        begin
            req_op = OP_EXEC;
            ea = ins[BIT_P] ? indexed_base(ins) : reg_image[ins[RN_LSB +: 4]];
            // never load a word that has not been written yet
            if (ins[BIT_L] && (ea >> 2) < MEM_WORDS && !mem_written[ea[MEM_AW+1:2]])
                ins[BIT_L] = 1'b0;
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        xfer_result_t want;
        if (rst_n && done)
        begin
            if (due_outputs.size() == 0)
            begin
                $display("%0t: result with no request pending", $time);
                mismatch_count++;
            end
            else
            begin
                want = due_outputs.pop_front();
                compare_field("effective_address", want.effective_address,
                              effective_address);
                compare_field("transfer_data", want.transfer_data, transfer_data);
                compare_field("base_after", want.base_after, base_after);
                compare_field("dest_reg", 32'(want.dest_reg), 32'(dest_reg));
                compare_field("was_load", 32'(want.was_load), 32'(was_load));
                compare_field("fault", 32'(want.fault), 32'(fault));
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results still pending", $time, due_outputs.size());
            $display("single_data_transfer_unit_tb failed");
            $finish;
        end
    end

    initial
    begin
        logic [1:0]   r_op;
        logic [31:0]  r_ins;
        logic [13:0]  r_idx;
        logic [31:0]  r_val;
        int           burst_left;
        int           gap;
        xfer_result_t none;

        rst_n <= 1'b0;
        start <= 1'b0;
        op <= OP_EXEC;
        instruction <= '0;
        preload_index <= '0;
        preload_value <= '0;
        foreach (reg_image[i])
            reg_image[i] = '0;
        none = '0;

        // registers read as zero after reset
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 1, 0, 4'd0, 4'd1, 12'd0),
                                  14'd0, 32'd0, 1, outcome(0, 0, 0, 4'd1, 0, 0)));
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 1, 1, 4'd0, 4'd2, 12'd0),
                                  14'd0, 32'd0, 1, outcome(0, 0, 0, 4'd2, 1, 0)));
        // preloads: in range, register index just past the file, index extremes
        script.push_back(stim_row(OP_LOAD_REG, 32'd0, 14'd15, 32'hFFFF_FFFF, 1, none));
        script.push_back(stim_row(OP_LOAD_REG, 32'd0, 14'd16, 32'h5555_5555, 1,
                                  outcome(0, 0, 0, 4'd0, 0, 1)));
        script.push_back(stim_row(OP_LOAD_REG, 32'd0, 14'h3FFF, 32'hAAAA_AAAA, 1,
                                  outcome(0, 0, 0, 4'd0, 0, 1)));
        script.push_back(stim_row(OP_LOAD_MEM, 32'd0, 14'h3FFF, 32'hA5A5_A5A5, 1, none));
        script.push_back(stim_row(OP_LOAD_MEM, 32'd0, 14'd0, 32'h1234_5678, 1, none));
        // unused opcode with every field at all ones
        script.push_back(stim_row(OP_NONE, 32'hFFFF_FFFF, 14'h3FFF, 32'hFFFF_FFFF, 1, none));
        // top of the address space faults
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 1, 0, 4'd15, 4'd3, 12'd0),
                                  14'd0, 32'd0, 1,
                                  outcome(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 4'd3, 0, 1)));
        // last memory word, then one word past it
        script.push_back(stim_row(OP_LOAD_REG, 32'd0, 14'd4, 32'h0000_FFFC, 1, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 1, 1, 4'd4, 4'd5, 12'd0),
                                  14'd0, 32'd0, 0, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 1, 1, 4'd4, 4'd5, 12'd4),
                                  14'd0, 32'd0, 0, none));
        // post-indexed store of the base register itself, largest offset down
        script.push_back(stim_row(OP_EXEC, encode_transfer(0, 0, 0, 4'd4, 4'd4, 12'hFFF),
                                  14'd0, 32'd0, 0, none));
        // post-indexed load into the base register, offset subtracted
        script.push_back(stim_row(OP_LOAD_REG, 32'd0, 14'd6, 32'h0000_0100, 1, none));
        script.push_back(stim_row(OP_LOAD_MEM, 32'd0, 14'h40, 32'hDEAD_BEEF, 1, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(0, 0, 1, 4'd6, 4'd6, 12'h010),
                                  14'd0, 32'd0, 0, none));
        // base wraps below zero on writeback
        script.push_back(stim_row(OP_EXEC, encode_transfer(0, 0, 0, 4'd0, 4'd8, 12'hFFF),
                                  14'd0, 32'd0, 0, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(1, 0, 1, 4'd6, 4'd7, 12'h0F0),
                                  14'd0, 32'd0, 0, none));
        // ignored bits all set; address wraps past 2^32
        script.push_back(stim_row(OP_EXEC, 32'hFFEF_FFFF, 14'd0, 32'd0, 0, none));
        script.push_back(stim_row(OP_EXEC, 32'hFFFF_FFFF, 14'd0, 32'd0, 0, none));
        // post-indexed faults leave the base alone
        script.push_back(stim_row(OP_EXEC, 32'h0000_0000, 14'd0, 32'd0, 0, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(0, 1, 1, 4'd0, 4'd9, 12'h123),
                                  14'd0, 32'd0, 0, none));
        script.push_back(stim_row(OP_EXEC, encode_transfer(0, 1, 0, 4'd6, 4'd2, 12'h7FC),
                                  14'd0, 32'd0, 0, none));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            issue_request(script[i].req_op, script[i].ins, script[i].idx, script[i].val,
                          script[i].typed, script[i].res);
            if (i % 4 == 3)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        drain_requests();

        burst_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            draw_request(r_op, r_ins, r_idx, r_val);
            issue_request(r_op, r_ins, r_idx, r_val, 0, none);
            if (n == RANDOM_REQUESTS / 3 || n == 2 * RANDOM_REQUESTS / 3)
                drain_requests();
            else if (burst_left == 0)
            begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 12);
                gap = $urandom_range(0, 7);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            else
                burst_left--;
        end
        drain_requests();
        repeat (8) @(posedge clk);

        $display("Sent %0d requests: %0d transfers (%0d loads), %0d faulting requests.",
                 request_count, transfer_count, load_count, fault_count);
        $display("Checked %0d results, %0d mismatches.", results_checked, mismatch_count);
        if (mismatch_count == 0 && due_outputs.size() == 0)
            $display("single_data_transfer_unit_tb passed");
        else
            $display("single_data_transfer_unit_tb failed");
        $finish;
    end

endmodule
